// File: rtl/core/lpr_pkg.sv
// Shared constants, types and helpers of the LRU page replacement unit.
package lpr_pkg;

  localparam int MaxFrames = 8;
  localparam int PageW     = 16;
  localparam int FrameIdxW = $clog2(MaxFrames);
  localparam int FrameCntW = $clog2(MaxFrames + 1);
  localparam int RankW     = $clog2(MaxFrames);
  localparam int CountW    = 32;
  localparam int CfgW      = 4;

  localparam logic [CfgW-1:0] FramesReset = CfgW'(3);

  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StScan   = 3'b010,
    StUpdate = 3'b100
  } lpr_state_e;

  typedef struct packed {
    logic                 re;
    logic [FrameIdxW-1:0] raddr;
    logic                 we;
    logic [FrameIdxW-1:0] waddr;
    logic [PageW-1:0]     wdata;
  } lpr_ram_req_t;

  typedef struct packed {
    logic                 page_fault;
    logic [FrameIdxW-1:0] frame_index;
    logic                 evicted_valid;
    logic [PageW-1:0]     evicted_page;
    logic [CountW-1:0]    fault_count;
  } lpr_result_t;

  // A frame count of zero acts as one, and anything above the built count acts as the maximum.
  function automatic logic [FrameCntW-1:0] clamp_frames(input logic [CfgW-1:0] value);
    logic [FrameCntW-1:0] res;
    if (value == '0) begin
      res = FrameCntW'(1);
    end else if (32'(value) > MaxFrames) begin
      res = FrameCntW'(MaxFrames);
    end else begin
      res = FrameCntW'(value);
    end
    return res;
  endfunction

endpackage

// File: rtl/core/lpr_page_ram.sv
// Page number store: one write port and one registered read port.
module lpr_page_ram
  import lpr_pkg::*;
(
  input  logic                 clk_i,
  input  lpr_ram_req_t         req_i,
  output logic [PageW-1:0]     rdata_o
);

  logic [PageW-1:0] mem_q [MaxFrames];
  logic [PageW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/lpr_core.sv
// Sequencer of the unit: frame scan over the page store, recency ranks and fault count.
module lpr_core
  import lpr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [PageW-1:0]     page_number_i,
  input  logic                 last_reference_i,
  input  logic [FrameCntW-1:0] used_i,
  output logic                 res_vld_o,
  input  logic                 res_ready_i,
  output lpr_result_t          res_o,
  output lpr_ram_req_t         ram_req_o,
  input  logic [PageW-1:0]     ram_rdata_i
);

  lpr_state_e             state_q, state_d;
  logic [PageW-1:0]       page_q, page_d;
  logic                   last_q, last_d;
  logic [FrameCntW-1:0]   used_q, used_d;
  logic [FrameCntW-1:0]   ptr_q, ptr_d;
  logic                   chk_q, chk_d;
  logic [FrameIdxW-1:0]   chk_idx_q, chk_idx_d;
  logic                   hit_q, hit_d;
  logic [FrameIdxW-1:0]   hit_idx_q, hit_idx_d;
  logic                   empty_q, empty_d;
  logic [FrameIdxW-1:0]   empty_idx_q, empty_idx_d;
  logic [FrameIdxW-1:0]   vic_idx_q, vic_idx_d;
  logic [RankW-1:0]       vic_rank_q, vic_rank_d;
  logic [PageW-1:0]       vic_page_q, vic_page_d;
  logic [MaxFrames-1:0]   valid_q, valid_d;
  logic [RankW-1:0]       rank_q [MaxFrames];
  logic [RankW-1:0]       rank_d [MaxFrames];
  logic [CountW-1:0]      fault_q, fault_d;

  logic                   cur_valid;
  logic [RankW-1:0]       cur_rank;
  logic [FrameIdxW-1:0]   sel_idx;
  logic                   age_all;
  logic [RankW-1:0]       limit;
  logic [CountW-1:0]      fault_inc;
  logic                   upd_fire;

  assign cur_valid = valid_q[chk_idx_q];
  assign cur_rank  = rank_q[chk_idx_q];
  assign sel_idx   = hit_q ? hit_idx_q : (empty_q ? empty_idx_q : vic_idx_q);
  assign age_all   = !hit_q && empty_q;
  assign limit     = rank_q[sel_idx];
  assign fault_inc = (fault_q == '1) ? fault_q : fault_q + CountW'(1);
  assign upd_fire  = (state_q == StUpdate) && res_ready_i;

  assign in_stall_o = (state_q != StIdle);
  assign res_vld_o  = (state_q == StUpdate);

  always_comb begin
    res_o.page_fault    = !hit_q;
    res_o.frame_index   = sel_idx;
    res_o.evicted_valid = !hit_q && !empty_q;
    res_o.evicted_page  = (!hit_q && !empty_q) ? vic_page_q : '0;
    res_o.fault_count   = hit_q ? fault_q : fault_inc;
  end

  always_comb begin
    state_d     = state_q;
    page_d      = page_q;
    last_d      = last_q;
    used_d      = used_q;
    ptr_d       = ptr_q;
    chk_d       = chk_q;
    chk_idx_d   = chk_idx_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    empty_d     = empty_q;
    empty_idx_d = empty_idx_q;
    vic_idx_d   = vic_idx_q;
    vic_rank_d  = vic_rank_q;
    vic_page_d  = vic_page_q;
    valid_d     = valid_q;
    rank_d      = rank_q;
    fault_d     = fault_q;
    ram_req_o   = '0;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          page_d  = page_number_i;
          last_d  = last_reference_i;
          used_d  = used_i;
          ptr_d   = '0;
          chk_d   = 1'b0;
          hit_d   = 1'b0;
          empty_d = 1'b0;
          state_d = StScan;
        end
      end
      StScan: begin
        // The frame read in the previous cycle is judged while the next one is read.
        if (chk_q) begin
          if (!hit_q && cur_valid && (ram_rdata_i == page_q)) begin
            hit_d     = 1'b1;
            hit_idx_d = chk_idx_q;
          end
          if (!hit_q && !cur_valid && !empty_q) begin
            empty_d     = 1'b1;
            empty_idx_d = chk_idx_q;
          end
          if ((chk_idx_q == '0) || (cur_rank > vic_rank_q)) begin
            vic_idx_d  = chk_idx_q;
            vic_rank_d = cur_rank;
            vic_page_d = ram_rdata_i;
          end
        end
        if (ptr_q < used_q) begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = ptr_q[FrameIdxW-1:0];
          chk_d           = 1'b1;
          chk_idx_d       = ptr_q[FrameIdxW-1:0];
          ptr_d           = ptr_q + FrameCntW'(1);
        end else begin
          chk_d   = 1'b0;
          state_d = StUpdate;
        end
      end
      StUpdate: begin
        if (res_ready_i) begin
          for (int j = 0; j < MaxFrames; j++) begin
            if ((FrameIdxW'(j) != sel_idx) && valid_q[j] && (age_all || (rank_q[j] < limit))) begin
              rank_d[j] = rank_q[j] + RankW'(1);
            end
          end
          rank_d[sel_idx]  = '0;
          valid_d[sel_idx] = 1'b1;
          if (!hit_q) begin
            fault_d         = fault_inc;
            ram_req_o.we    = 1'b1;
            ram_req_o.waddr = sel_idx;
            ram_req_o.wdata = page_q;
          end
          // The last reference of a string empties the frames and clears the fault count once its result is taken.
          if (last_q) begin
            valid_d = '0;
            fault_d = '0;
            for (int j = 0; j < MaxFrames; j++) begin
              rank_d[j] = '0;
            end
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      chk_q   <= 1'b0;
      ptr_q   <= '0;
      valid_q <= '0;
      fault_q <= '0;
      for (int j = 0; j < MaxFrames; j++) begin
        rank_q[j] <= '0;
      end
    end else begin
      state_q <= state_d;
      chk_q   <= chk_d;
      ptr_q   <= ptr_d;
      valid_q <= valid_d;
      fault_q <= fault_d;
      rank_q  <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q      <= page_d;
    last_q      <= last_d;
    used_q      <= used_d;
    chk_idx_q   <= chk_idx_d;
    hit_q       <= hit_d;
    hit_idx_q   <= hit_idx_d;
    empty_q     <= empty_d;
    empty_idx_q <= empty_idx_d;
    vic_idx_q   <= vic_idx_d;
    vic_rank_q  <= vic_rank_d;
    vic_page_q  <= vic_page_d;
  end

`ifndef SYNTH
  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> (ptr_q <= used_q))
    else $error("scan pointer ran past the frames in use");

  a_hit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_fire && hit_q) |-> (FrameCntW'(hit_idx_q) < used_q))
    else $error("hit reported outside the frames in use");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_fire && last_q) |=> ((valid_q == '0) && (fault_q == '0)))
    else $error("frames not cleared after the last reference");

  a_count_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_fire && !last_q) |=> (fault_q >= $past(fault_q)))
    else $error("fault count went down without a clear");
`endif

endmodule

// File: rtl/core/lru_page_replacement_unit.sv
// LRU page replacement unit: configuration register, result register and the datapath.
//
// Each page reference is handled in steps: the unit accepts it, reads the page store once per
// frame in use, compares the last frame read, and then an update step writes the page store,
// ages the recency ranks and hands the result to the output register, waiting while that
// register cannot take it. The page store has a single read port, so the scan reads one frame
// at a time. A new reference is taken while the previous result still waits in the output
// register. Configuration writes are taken at any time but belong to idle periods.
module lru_page_replacement_unit
  import lpr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgW-1:0]      cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [PageW-1:0]     page_number_i,
  input  logic                 last_reference_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 page_fault_o,
  output logic [FrameIdxW-1:0] frame_index_o,
  output logic                 evicted_valid_o,
  output logic [PageW-1:0]     evicted_page_o,
  output logic [CountW-1:0]    fault_count_o
);

  logic [CfgW-1:0]  frames_in_use_q;
  logic             out_vld_q;
  lpr_result_t      out_q;
  lpr_result_t      res;
  logic             res_vld;
  logic             res_ready;
  lpr_ram_req_t     ram_req;
  logic [PageW-1:0] ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_in_use_q <= FramesReset;
    end else if (cfg_we_i) begin
      frames_in_use_q <= cfg_wdata_i;
    end
  end

  lpr_page_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  lpr_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .page_number_i    (page_number_i),
    .last_reference_i (last_reference_i),
    .used_i           (clamp_frames(frames_in_use_q)),
    .res_vld_o        (res_vld),
    .res_ready_i      (res_ready),
    .res_o            (res),
    .ram_req_o        (ram_req),
    .ram_rdata_i      (ram_rdata)
  );

  // The output register takes a new result when it is empty or its transfer completes now.
  assign res_ready = !out_vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_ready) begin
      out_vld_q <= res_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_vld) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign page_fault_o    = out_q.page_fault;
  assign frame_index_o   = out_q.frame_index;
  assign evicted_valid_o = out_q.evicted_valid;
  assign evicted_page_o  = out_q.evicted_page;
  assign fault_count_o   = out_q.fault_count;

endmodule
